FILE: rtl/htd_pkg.sv
package htd_pkg;

	localparam int IDX_W = 9;
	localparam int SYM_W = 8;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ERR,
		RES_SYM
	} res_kind_t;

	typedef struct packed {
		logic      load_wr;
		logic      rd_pos;
		logic      rd_child;
		logic      walk_clear;
		logic      walk_step;
		logic      out_wr;
		res_kind_t out_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic node_leaf;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/htd_dp.sv
module htd_dp #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  htd_pkg::dp_cmd_t          cmd,
	output htd_pkg::dp_stat_t         stat,
	input  logic                      cfg_wr_en,
	input  logic [htd_pkg::IDX_W-1:0] cfg_wr_data,
	input  logic [htd_pkg::IDX_W-1:0] node_index,
	input  logic [htd_pkg::IDX_W-1:0] left_child,
	input  logic [htd_pkg::IDX_W-1:0] right_child,
	input  logic                      node_is_leaf,
	input  logic [htd_pkg::SYM_W-1:0] node_symbol,
	input  logic                      code_bit,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic                      symbol_valid,
	output logic [htd_pkg::SYM_W-1:0] symbol,
	output logic                      leaf_root_error
);

	localparam int AW = $clog2(NODE_COUNT);
	localparam int IW = htd_pkg::IDX_W;
	localparam int SW = htd_pkg::SYM_W;

	typedef struct packed {
		logic [AW-1:0]          left;
		logic [AW-1:0]          right;
		logic                   leaf;
		logic [SYMBOL_BITS-1:0] sym;
	} entry_t;

	// index mod NODE_COUNT by restoring compare-subtract against shifted constants
	function automatic logic [AW-1:0] wrap_idx(input logic [IW-1:0] v);
		logic [IW-1:0] r;
		r = v;
		for (int k = IW - 1; k >= 0; k--) begin
			if ((NODE_COUNT << k) < (1 << IW)) begin
				if (32'(r) >= (NODE_COUNT << k)) begin
					r = r - IW'(NODE_COUNT << k);
				end
			end
		end
		return AW'(r);
	endfunction

	entry_t        mem_q [NODE_COUNT];
	entry_t        rd_q;
	entry_t        wr_entry;
	logic [AW-1:0] root_q;
	logic [AW-1:0] cur_q;
	logic          mid_q;
	logic [AW-1:0] nxt_q;
	logic          bit_q;
	logic          out_valid_q;
	logic          symbol_valid_q;
	logic [SW-1:0] symbol_q;
	logic          leaf_root_error_q;
	logic [AW-1:0] pos;
	logic [AW-1:0] child;
	logic [AW-1:0] rd_addr;

	assign pos     = mid_q ? cur_q : root_q;
	assign child   = bit_q ? rd_q.right : rd_q.left;
	assign rd_addr = cmd.rd_pos ? pos : child;

	always_comb begin
		wr_entry.left  = wrap_idx(left_child);
		wr_entry.right = wrap_idx(right_child);
		wr_entry.leaf  = node_is_leaf;
		wr_entry.sym   = SYMBOL_BITS'(node_symbol);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem_q[wrap_idx(node_index)] <= wr_entry;
		end
		if (cmd.rd_pos || cmd.rd_child) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.rd_pos) begin
			bit_q <= code_bit;
		end
		if (cmd.rd_child) begin
			nxt_q <= child;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			cur_q  <= '0;
			mid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				root_q <= wrap_idx(cfg_wr_data);
			end
			if (cmd.walk_clear) begin
				cur_q <= '0;
				mid_q <= 1'b0;
			end else if (cmd.walk_step) begin
				cur_q <= nxt_q;
				mid_q <= 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			unique case (cmd.out_kind)
				htd_pkg::RES_ERR: begin
					symbol_valid_q    <= 1'b0;
					symbol_q          <= '0;
					leaf_root_error_q <= 1'b1;
				end
				htd_pkg::RES_SYM: begin
					symbol_valid_q    <= 1'b1;
					symbol_q          <= SW'(rd_q.sym);
					leaf_root_error_q <= 1'b0;
				end
				default: begin
					symbol_valid_q    <= 1'b0;
					symbol_q          <= '0;
					leaf_root_error_q <= 1'b0;
				end
			endcase
		end
	end

	assign stat.node_leaf = rd_q.leaf;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign symbol_valid    = symbol_valid_q;
	assign symbol          = symbol_q;
	assign leaf_root_error = leaf_root_error_q;

endmodule

FILE: rtl/htd_ctrl.sv
module htd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  htd_pkg::dp_stat_t stat,
	output htd_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_POS,
		S_NEXT
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == htd_pkg::CMD_LOAD) begin
						cmd.load_wr    = 1'b1;
						cmd.walk_clear = 1'b1;
					end else begin
						cmd.rd_pos = 1'b1;
					end
				end
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_kind = htd_pkg::RES_NONE;
				end
			end
			S_POS: begin
				if (stat.node_leaf) begin
					if (stat.out_free) begin
						cmd.out_wr     = 1'b1;
						cmd.out_kind   = htd_pkg::RES_ERR;
						cmd.walk_clear = 1'b1;
					end
				end else begin
					cmd.rd_child = 1'b1;
				end
			end
			S_NEXT: begin
				if (stat.out_free) begin
					cmd.out_wr = 1'b1;
					if (stat.node_leaf) begin
						cmd.out_kind   = htd_pkg::RES_SYM;
						cmd.walk_clear = 1'b1;
					end else begin
						cmd.out_kind  = htd_pkg::RES_NONE;
						cmd.walk_step = 1'b1;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (command == htd_pkg::CMD_LOAD) ? S_LOAD : S_POS;
					end
				end
				S_LOAD: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_POS: begin
					if (!stat.node_leaf) begin
						state_q <= S_NEXT;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_NEXT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/huffman_tree_decode_top.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  command, node_index, left_child, right_child,
//                                          node_is_leaf, node_symbol, code_bit
// out      output     out_valid / out_stall symbol_valid, symbol, leaf_root_error
// cfg      input      cfg_wr_en            cfg_wr_data (root_node)
//
// Load word: table write on accept, then output. Decode word: node read, then dependent child
// read of the single-port node table, then output; a leaf root skips the child read (error).
// arst_n clears the walk, root_node and the output valid; the node table is not cleared.
// A held output word stalls only the output step; the next input word can be taken.
module huffman_tree_decode_top #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [htd_pkg::IDX_W-1:0] node_index,
	input  logic [htd_pkg::IDX_W-1:0] left_child,
	input  logic [htd_pkg::IDX_W-1:0] right_child,
	input  logic                      node_is_leaf,
	input  logic [htd_pkg::SYM_W-1:0] node_symbol,
	input  logic                      code_bit,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      symbol_valid,
	output logic [htd_pkg::SYM_W-1:0] symbol,
	output logic                      leaf_root_error,
	input  logic                      cfg_wr_en,
	input  logic [htd_pkg::IDX_W-1:0] cfg_wr_data
);

	htd_pkg::dp_cmd_t  cmd;
	htd_pkg::dp_stat_t stat;

	htd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	htd_dp #(
		.NODE_COUNT  (NODE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.node_index      (node_index),
		.left_child      (left_child),
		.right_child     (right_child),
		.node_is_leaf    (node_is_leaf),
		.node_symbol     (node_symbol),
		.code_bit        (code_bit),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.symbol_valid    (symbol_valid),
		.symbol          (symbol),
		.leaf_root_error (leaf_root_error)
	);

endmodule

FILE: rtl/htd_chk.sv
module htd_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      symbol_valid,
	input logic [htd_pkg::SYM_W-1:0] symbol,
	input logic                      leaf_root_error
);

	// held output word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(symbol_valid) && $stable(symbol)
			&& $stable(leaf_root_error))
		else $error("output word changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(symbol_valid && leaf_root_error))
		else $error("symbol and leaf-root error together");

	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !symbol_valid |-> symbol == '0)
		else $error("symbol not zero without symbol_valid");

	// every accepted word makes the block busy: in_stall rises after each acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word without a word in flight");

endmodule

bind huffman_tree_decode_top htd_chk u_htd_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.symbol_valid    (symbol_valid),
	.symbol          (symbol),
	.leaf_root_error (leaf_root_error)
);

FILE: test/testbench.sv
module testbench;

	localparam int IW = htd_pkg::IDX_W;
	localparam int SW = htd_pkg::SYM_W;
	localparam int NODES = 1 << IW;
	localparam int GEN = 0;
	localparam int CHK = 1;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 12;

	typedef logic [IW-1:0] idx_t;
	typedef logic [SW-1:0] sym_t;

	localparam idx_t LAST_IDX = idx_t'(NODES - 1);

	typedef struct packed {
		htd_pkg::cmd_code_t command;
		idx_t               node_index;
		idx_t               left_child;
		idx_t               right_child;
		logic               node_is_leaf;
		sym_t               node_symbol;
		logic               code_bit;
	} code_word_t;

	typedef struct packed {
		logic symbol_valid;
		sym_t symbol;
		logic leaf_root_error;
	} sym_word_t;

	typedef struct packed {
		idx_t left;
		idx_t right;
		logic leaf;
		sym_t sym;
	} tree_node_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	idx_t node_index = '0;
	idx_t left_child = '0;
	idx_t right_child = '0;
	logic node_is_leaf = 1'b0;
	sym_t node_symbol = '0;
	logic code_bit = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic symbol_valid;
	sym_t symbol;
	logic leaf_root_error;
	logic cfg_wr_en = 1'b0;
	idx_t cfg_wr_data = '0;

	// index GEN: state seen by the stimulus generator; CHK: state at acceptance
	tree_node_t  node_mem [2][NODES];
	bit          node_set [2][NODES];
	bit [IW-1:0] walk_pos [2];
	bit          in_code [2];
	bit [IW-1:0] root_idx [2];

	code_word_t code_words [$];
	sym_word_t  due_symbols [$];
	code_word_t cur_word;
	int         in_gap = 0;
	int         st_gap = 0;
	int         mismatches = 0;
	bit         no_idle = 1'b0;
	logic       hold_start = 1'b0;
	int         hold_left = 0;
	sym_word_t  got;
	sym_word_t  want;

	huffman_tree_decode_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.node_index     (node_index),
		.left_child     (left_child),
		.right_child    (right_child),
		.node_is_leaf   (node_is_leaf),
		.node_symbol    (node_symbol),
		.code_bit       (code_bit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.symbol_valid   (symbol_valid),
		.symbol         (symbol),
		.leaf_root_error(leaf_root_error),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic sym_word_t walk_step(input int m, input code_word_t w);
		sym_word_t res;
		idx_t      pos;
		idx_t      nxt;
		res = '0;
		if (w.command == htd_pkg::CMD_LOAD) begin
			node_mem[m][w.node_index] = '{w.left_child, w.right_child, w.node_is_leaf,
				w.node_symbol};
			node_set[m][w.node_index] = 1'b1;
			walk_pos[m] = '0;
			in_code[m] = 1'b0;
		end else begin
			pos = in_code[m] ? walk_pos[m] : root_idx[m];
			if (node_mem[m][pos].leaf) begin
				res.leaf_root_error = 1'b1;
				walk_pos[m] = '0;
				in_code[m] = 1'b0;
			end else begin
				nxt = w.code_bit ? node_mem[m][pos].right : node_mem[m][pos].left;
				if (node_mem[m][nxt].leaf) begin
					res.symbol_valid = 1'b1;
					res.symbol = node_mem[m][nxt].sym;
					walk_pos[m] = '0;
					in_code[m] = 1'b0;
				end else begin
					walk_pos[m] = nxt;
					in_code[m] = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// 1 when a decode with bit b would read an entry never loaded; idx names it
	function automatic bit needs_node(input logic b, output idx_t idx);
		idx_t pos;
		pos = in_code[GEN] ? walk_pos[GEN] : root_idx[GEN];
		idx = pos;
		if (!node_set[GEN][pos])
			return 1'b1;
		if (node_mem[GEN][pos].leaf)
			return 1'b0;
		idx = b ? node_mem[GEN][pos].right : node_mem[GEN][pos].left;
		return !node_set[GEN][idx];
	endfunction

	function automatic code_word_t mk_load(input idx_t idx, input idx_t l, input idx_t r,
		input logic leaf, input sym_t sym);
		code_word_t w;
		w.command = htd_pkg::CMD_LOAD;
		w.node_index = idx;
		w.left_child = l;
		w.right_child = r;
		w.node_is_leaf = leaf;
		w.node_symbol = sym;
		w.code_bit = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic code_word_t mk_bit(input logic b);
		code_word_t w;
		w.command = htd_pkg::CMD_DECODE;
		w.node_index = idx_t'($urandom_range(0, NODES - 1));
		w.left_child = idx_t'($urandom_range(0, NODES - 1));
		w.right_child = idx_t'($urandom_range(0, NODES - 1));
		w.node_is_leaf = 1'($urandom_range(0, 1));
		w.node_symbol = sym_t'($urandom_range(0, 255));
		w.code_bit = b;
		return w;
	endfunction

	task automatic push_word(input code_word_t w);
		void'(walk_step(GEN, w));
		code_words.insert(code_words.size(), w);
	endtask

	task automatic random_bit();
		logic b;
		idx_t gap;
		b = 1'($urandom_range(0, 1));
		if (needs_node(b, gap))
			b = ~b;
		if (needs_node(b, gap))
			push_word(mk_load(gap, idx_t'($urandom_range(0, NODES - 1)),
				idx_t'($urandom_range(0, NODES - 1)), 1'b1, sym_t'($urandom_range(0, 255))));
		else
			push_word(mk_bit(b));
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (code_words.size() != 0 || in_valid || due_symbols.size() != 0);
	endtask

	task automatic set_root(input idx_t r);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		root_idx[GEN] = r;
		root_idx[CHK] = r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input idx_t root, input int leaves,
		input int n_words, input bit squeeze);
		idx_t open_q [$];
		bit   taken [NODES];
		idx_t p;
		idx_t a;
		idx_t b;
		int   k;
		set_root(root);
		if (squeeze) begin
			@(posedge clk);
			hold_start <= 1'b1;
			@(posedge clk);
			hold_start <= 1'b0;
		end
		foreach (taken[i])
			taken[i] = 1'b0;
		open_q.insert(open_q.size(), root);
		taken[root] = 1'b1;
		while (open_q.size() < leaves) begin
			k = $urandom_range(0, open_q.size() - 1);
			p = open_q[k];
			open_q.delete(k);
			do a = idx_t'($urandom_range(0, NODES - 1)); while (taken[a]);
			taken[a] = 1'b1;
			do b = idx_t'($urandom_range(0, NODES - 1)); while (taken[b]);
			taken[b] = 1'b1;
			push_word(mk_load(p, a, b, 1'b0, sym_t'($urandom_range(0, 255))));
			open_q.insert(open_q.size(), a);
			open_q.insert(open_q.size(), b);
		end
		foreach (open_q[i])
			push_word(mk_load(open_q[i], idx_t'($urandom_range(0, NODES - 1)),
				idx_t'($urandom_range(0, NODES - 1)), 1'b1, sym_t'($urandom_range(0, 255))));
		for (k = 0; k < n_words; k++) begin
			if ($urandom_range(0, 99) < 4)
				push_word(mk_load(idx_t'(($urandom_range(0, 3) == 0) ? root :
					$urandom_range(0, NODES - 1)), idx_t'($urandom_range(0, NODES - 1)),
					idx_t'($urandom_range(0, NODES - 1)), 1'($urandom_range(0, 1)),
					sym_t'($urandom_range(0, 255))));
			else
				random_bit();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			due_symbols.insert(due_symbols.size(), walk_step(CHK, cur_word));
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_gap != 0) begin
				in_gap = in_gap - 1;
				in_valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (code_words.size() != 0) begin
				cur_word = code_words.pop_front();
				command <= cur_word.command;
				node_index <= cur_word.node_index;
				left_child <= cur_word.left_child;
				right_child <= cur_word.right_child;
				node_is_leaf <= cur_word.node_is_leaf;
				node_symbol <= cur_word.node_symbol;
				code_bit <= cur_word.code_bit;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = '{symbol_valid, symbol, leaf_root_error};
			if (due_symbols.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected symbol word: valid=%0b sym=%02h err=%0b",
						got.symbol_valid, got.symbol, got.leaf_root_error);
			end else begin
				want = due_symbols.pop_front();
				if (got.symbol_valid !== want.symbol_valid || got.symbol !== want.symbol ||
					got.leaf_root_error !== want.leaf_root_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("symbol word: expected valid=%0b sym=%02h err=%0b, %s%0b %s%02h %s%0b",
							want.symbol_valid, want.symbol, want.leaf_root_error,
							"got valid=", got.symbol_valid, "sym=", got.symbol,
							"err=", got.leaf_root_error);
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
		end else if (st_gap != 0) begin
			st_gap = st_gap - 1;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			st_gap = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_word(mk_load('0, LAST_IDX, idx_t'(1), 1'b0, 8'h00));
		push_word(mk_load(LAST_IDX, '0, LAST_IDX, 1'b1, 8'hff));
		push_word(mk_load(idx_t'(1), idx_t'(1), idx_t'(2), 1'b0, 8'h3c));
		push_word(mk_load(idx_t'(2), LAST_IDX, LAST_IDX, 1'b1, 8'h00));
		push_word(mk_bit(1'b0));
		push_word(mk_bit(1'b1));
		// self loop keeps the walk inside the code word
		push_word(mk_bit(1'b0));
		push_word(mk_bit(1'b1));
		push_word(mk_bit(1'b1));
		// load in the middle of a code word restarts at the root
		push_word(mk_load(idx_t'(3), '0, '0, 1'b1, 8'h5a));
		push_word(mk_bit(1'b0));
		// root entry turned into a leaf
		push_word(mk_load('0, '0, '0, 1'b1, 8'haa));
		push_word(mk_bit(1'b1));
		push_word(mk_bit(1'b0));
		push_word(mk_load('0, LAST_IDX, idx_t'(1), 1'b0, 8'h00));
		push_word(mk_bit(1'b1));
		// root moved while inside a code word; new root is a leaf
		set_root(LAST_IDX);
		push_word(mk_bit(1'b1));
		push_word(mk_bit(1'b0));
		set_root(idx_t'(1));
		push_word(mk_bit(1'b1));
		push_word(mk_bit(1'b0));
		push_word(mk_bit(1'b1));
		set_root('0);
		push_word(mk_bit(1'b0));

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1)
				no_idle = 1'b1;
			run_phase(idx_t'((ph == 0) ? NODES - 1 : (ph == 1) ? 0 :
				$urandom_range(0, NODES - 1)),
				(ph == 3) ? 1 : (ph == 0) ? 2 : $urandom_range(2, 48), 100, ph == 2);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/htd_pkg.sv
rtl/htd_dp.sv
rtl/htd_ctrl.sv
rtl/huffman_tree_decode_top.sv
rtl/htd_chk.sv
test/testbench.sv
